### hw/rtl/nwt_pkg.sv
// shared types and codes for the nearest waypoint trim block
package nwt_pkg;

	localparam int IDX_W = 6;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_QUERY
	} op_e_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_WAIT
	} back_state_t;

	typedef struct packed {
		logic valid;
		logic last;
	} scan_tag_t;

endpackage

### hw/rtl/nearest_waypoint_trim.sv
// top level of the nearest waypoint trim block
// input channel: in_valid/in_ready carry one word of action, point_x, point_y.
// action clear empties the table, append stores a waypoint (dropped when full),
// query finds the first nearest stored waypoint by squared distance and emits
// every waypoint from it to the end of the table; action 3 is discarded.
// output channel: out_valid/out_ready carry found, waypoint_index, out_x, out_y
// and last; last marks the final word of a query, and a query on an empty
// table gives one word with found low.
// a two-entry command queue decouples input from the back end, so up to two
// words are taken in while a query runs.
// clear and append take effect as the back end takes them and can follow back to back;
// a query over n waypoints holds the back end while it takes the command,
// scans the n waypoints through the single memory read port, drains the read
// and distance pipeline, reads and loads each emitted word in turn and frees
// the output register.
// a query on an empty table holds the back end until its word is taken.
// a back-end word starts only once the output register is free.
// when the receiver stalls the output register holds, the back end waits,
// and in_ready falls once the queue is full.
// reset empties the table and the queue; no clearing pass is needed.
module nearest_waypoint_trim import nwt_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [IDX_W-1:0]             waypoint_index,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic                         last
);

	logic                         cmd_valid;
	logic                         cmd_ready;
	op_e_t                        cmd_op;
	logic signed [COORD_BITS-1:0] cmd_x;
	logic signed [COORD_BITS-1:0] cmd_y;

	nwt_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.point_x  (point_x),
		.point_y  (point_y),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_op   (cmd_op),
		.cmd_x    (cmd_x),
		.cmd_y    (cmd_y)
	);

	nwt_back #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd_op        (cmd_op),
		.cmd_x         (cmd_x),
		.cmd_y         (cmd_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.waypoint_index(waypoint_index),
		.out_x         (out_x),
		.out_y         (out_y),
		.last          (last)
	);

endmodule

### hw/rtl/nwt_front.sv
// input side: classifies words and queues commands for the back end
module nwt_front import nwt_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         cmd_valid,
	input  logic                         cmd_ready,
	output op_e_t                        cmd_op,
	output logic signed [COORD_BITS-1:0] cmd_x,
	output logic signed [COORD_BITS-1:0] cmd_y
);

	logic                         keep;
	op_e_t                        op_in;
	logic                         push;
	logic                         pop;
	op_e_t                        op_q [2];
	logic signed [COORD_BITS-1:0] x_q  [2];
	logic signed [COORD_BITS-1:0] y_q  [2];
	logic                         wr_ptr_q;
	logic                         rd_ptr_q;
	logic [1:0]                   fill_q;

	always_comb begin
		case (action)
			ACT_CLEAR: begin
				keep  = 1'b1;
				op_in = OP_CLEAR;
			end
			ACT_APPEND: begin
				keep  = 1'b1;
				op_in = OP_APPEND;
			end
			ACT_QUERY: begin
				keep  = 1'b1;
				op_in = OP_QUERY;
			end
			default: begin
				keep  = 1'b0;
				op_in = OP_CLEAR;
			end
		endcase
	end

	assign in_ready  = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign push      = in_valid && in_ready && keep;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd_op    = op_q[rd_ptr_q];
	assign cmd_x     = x_q[rd_ptr_q];
	assign cmd_y     = y_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q] <= op_in;
			x_q[wr_ptr_q]  <= point_x;
			y_q[wr_ptr_q]  <= point_y;
		end
	end

endmodule

### hw/rtl/nwt_dist.sv
// squared distance pipeline: difference, square, sum
module nwt_dist import nwt_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int AW = 6,
	localparam int DW = 2*COORD_BITS+1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  scan_tag_t                    tag_s1,
	input  logic [AW-1:0]                idx_s1,
	input  logic signed [COORD_BITS-1:0] x_s1,
	input  logic signed [COORD_BITS-1:0] y_s1,
	input  logic signed [COORD_BITS-1:0] qx,
	input  logic signed [COORD_BITS-1:0] qy,
	output scan_tag_t                    tag_s4,
	output logic [AW-1:0]                idx_s4,
	output logic [DW-1:0]                dist_s4
);

	logic [COORD_BITS:0]     ex_d;
	logic [COORD_BITS:0]     ey_d;
	logic [COORD_BITS:0]     ex_m;
	logic [COORD_BITS:0]     ey_m;
	scan_tag_t               tag_s2;
	scan_tag_t               tag_s3;
	logic [AW-1:0]           idx_s2;
	logic [AW-1:0]           idx_s3;
	logic [COORD_BITS-1:0]   dx_s2;
	logic [COORD_BITS-1:0]   dy_s2;
	logic [2*COORD_BITS-1:0] sqx_s3;
	logic [2*COORD_BITS-1:0] sqy_s3;

	assign ex_d = {x_s1[COORD_BITS-1], x_s1} - {qx[COORD_BITS-1], qx};
	assign ey_d = {y_s1[COORD_BITS-1], y_s1} - {qy[COORD_BITS-1], qy};
	assign ex_m = ex_d[COORD_BITS] ? (~ex_d + 1'b1) : ex_d;
	assign ey_m = ey_d[COORD_BITS] ? (~ey_d + 1'b1) : ey_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2  <= idx_s1;
		dx_s2   <= ex_m[COORD_BITS-1:0];
		dy_s2   <= ey_m[COORD_BITS-1:0];
		idx_s3  <= idx_s2;
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
		idx_s4  <= idx_s3;
		dist_s4 <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
	end

endmodule

### hw/rtl/nwt_back.sv
// back end: waypoint memory, nearest scan and trimmed path output
module nwt_back import nwt_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  op_e_t                        cmd_op,
	input  logic signed [COORD_BITS-1:0] cmd_x,
	input  logic signed [COORD_BITS-1:0] cmd_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [IDX_W-1:0]             waypoint_index,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic                         last
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS+1);
	localparam int DW = 2*COORD_BITS+1;

	back_state_t                  state_q;
	back_state_t                  state_d;
	logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
	logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];
	logic signed [COORD_BITS-1:0] rd_x_s1;
	logic signed [COORD_BITS-1:0] rd_y_s1;
	scan_tag_t                    tag_s1;
	logic [AW-1:0]                idx_s1;
	scan_tag_t                    tag_s4;
	logic [AW-1:0]                idx_s4;
	logic [DW-1:0]                dist_s4;
	logic [CW-1:0]                cnt_q;
	logic [AW-1:0]                idx_q;
	logic [AW-1:0]                best_q;
	logic [DW-1:0]                best_d_q;
	logic signed [COORD_BITS-1:0] qx_q;
	logic signed [COORD_BITS-1:0] qy_q;
	logic                         out_valid_q;
	logic                         pop;
	logic                         idx_is_last;
	logic                         better;
	logic                         do_append;
	logic                         empty_query;
	logic                         start_scan;
	logic                         emit_load;
	logic                         scan_done;

	assign cmd_ready   = (state_q == ST_IDLE) && !out_valid_q;
	assign pop         = cmd_valid && cmd_ready;
	assign idx_is_last = (CW'(idx_q) == (cnt_q - 1'b1));
	assign do_append   = pop && (cmd_op == OP_APPEND) && (cnt_q < CW'(MAX_POINTS));
	assign empty_query = pop && (cmd_op == OP_QUERY) && (cnt_q == '0);
	assign start_scan  = pop && (cmd_op == OP_QUERY) && (cnt_q != '0);
	assign better      = tag_s4.valid && ((idx_s4 == '0) || (dist_s4 < best_d_q));
	assign scan_done   = tag_s4.valid && tag_s4.last;
	assign emit_load   = (state_q == ST_EMIT_WAIT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_scan)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (idx_is_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (scan_done)
					state_d = ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (emit_load)
					state_d = idx_is_last ? ST_IDLE : ST_EMIT_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// waypoint memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (do_append) begin
			mem_x[cnt_q[AW-1:0]] <= cmd_x;
			mem_y[cnt_q[AW-1:0]] <= cmd_y;
		end
		rd_x_s1 <= mem_x[idx_q];
		rd_y_s1 <= mem_y[idx_q];
		idx_s1  <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			tag_s1.valid <= (state_q == ST_SCAN);
			tag_s1.last  <= idx_is_last;
			if (pop && (cmd_op == OP_CLEAR))
				cnt_q <= '0;
			else if (do_append)
				cnt_q <= cnt_q + 1'b1;
			if (start_scan)
				idx_q <= '0;
			else if ((state_q == ST_SCAN) && !idx_is_last)
				idx_q <= idx_q + 1'b1;
			else if ((state_q == ST_DRAIN) && scan_done)
				idx_q <= better ? idx_s4 : best_q;
			else if (emit_load && !idx_is_last)
				idx_q <= idx_q + 1'b1;
			if (empty_query || emit_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_scan) begin
			qx_q <= cmd_x;
			qy_q <= cmd_y;
		end
		if (better) begin
			best_q   <= idx_s4;
			best_d_q <= dist_s4;
		end
		if (empty_query) begin
			found          <= 1'b0;
			waypoint_index <= '0;
			out_x          <= '0;
			out_y          <= '0;
			last           <= 1'b1;
		end else if (emit_load) begin
			found          <= 1'b1;
			waypoint_index <= IDX_W'(idx_q);
			out_x          <= rd_x_s1;
			out_y          <= rd_y_s1;
			last           <= idx_is_last;
		end
	end

	assign out_valid = out_valid_q;

	nwt_dist #(
		.COORD_BITS(COORD_BITS),
		.AW        (AW)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_s1 (tag_s1),
		.idx_s1 (idx_s1),
		.x_s1   (rd_x_s1),
		.y_s1   (rd_y_s1),
		.qx     (qx_q),
		.qy     (qy_q),
		.tag_s4 (tag_s4),
		.idx_s4 (idx_s4),
		.dist_s4(dist_s4)
	);

endmodule
